// ===== hdl/acpm_pkg.sv =====
package acpm_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int ACC_W           = 36;
  localparam int POWER_SHIFT     = 8;
  localparam int PWR_W           = ACC_W - POWER_SHIFT;
  localparam int CNT_W           = 12;
  localparam int HYST_W          = 8;
  localparam int LIM_W           = 11;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;

  localparam logic [HYST_W-1:0] HYST_RST = 8'd10;
  localparam logic [LIM_W-1:0]  PMIN_RST = 11'd100;
  localparam logic [LIM_W-1:0]  WMIN_RST = 11'd240;
  localparam logic [LIM_W-1:0]  WMAX_RST = 11'd1200;

  typedef enum logic [1:0] {
    REG_HYST,
    REG_POL_MIN,
    REG_WIN_MIN,
    REG_WIN_MAX
  } reg_idx_e;

  typedef struct packed {
    logic [HYST_W-1:0] hyst;
    logic [LIM_W-1:0]  pol_min;
    logic [LIM_W-1:0]  win_min;
    logic [LIM_W-1:0]  win_max;
  } cfg_t;

  typedef struct packed {
    logic rise;
    logic fall;
  } pol_cond_t;

endpackage

// ===== hdl/acpm_regs.sv =====
module acpm_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [acpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [acpm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output acpm_pkg::cfg_t                    cfg_o
);
  import acpm_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hyst    <= HYST_RST;
      cfg_q.pol_min <= PMIN_RST;
      cfg_q.win_min <= WMIN_RST;
      cfg_q.win_max <= WMAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_HYST:    cfg_q.hyst    <= pwdata[HYST_W-1:0];
        REG_POL_MIN: cfg_q.pol_min <= pwdata[LIM_W-1:0];
        REG_WIN_MIN: cfg_q.win_min <= pwdata[LIM_W-1:0];
        REG_WIN_MAX: cfg_q.win_max <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HYST:    prdata = CFG_DATA_W'(cfg_q.hyst);
      REG_POL_MIN: prdata = CFG_DATA_W'(cfg_q.pol_min);
      REG_WIN_MIN: prdata = CFG_DATA_W'(cfg_q.win_min);
      REG_WIN_MAX: prdata = CFG_DATA_W'(cfg_q.win_max);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== hdl/acpm_front.sv =====
module acpm_front #(
  parameter int SAMPLE_BITS = acpm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [SAMPLE_BITS-1:0]     line_i,
  input  logic [SAMPLE_BITS-1:0]     neut_i,
  input  logic [SAMPLE_BITS-1:0]     curr_i,
  input  acpm_pkg::cfg_t             cfg_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [2*SAMPLE_BITS-1:0]   volt_sq_o,
  output logic [2*SAMPLE_BITS-1:0]   curr_sq_o,
  output logic [2*SAMPLE_BITS-1:0]   power_o,
  output acpm_pkg::pol_cond_t        cond_o
);
  import acpm_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int CMP_W  = SAMPLE_BITS + 1;

  logic                   valid_q;
  logic [PROD_W-1:0]      volt_sq_q, curr_sq_q, power_q;
  pol_cond_t              cond_q, cond_d;
  logic [SAMPLE_BITS-1:0] volt;
  logic [CMP_W-1:0]       line_x, neut_x, hyst_x;
  logic                   accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    line_x      = CMP_W'(line_i);
    neut_x      = CMP_W'(neut_i);
    hyst_x      = CMP_W'(cfg_i.hyst);
    volt        = (line_i > neut_i) ? (line_i - neut_i) : (neut_i - line_i);
    cond_d.rise = line_x > (neut_x + hyst_x);
    cond_d.fall = neut_x > (line_x + hyst_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      volt_sq_q <= PROD_W'(volt) * PROD_W'(volt);
      curr_sq_q <= PROD_W'(curr_i) * PROD_W'(curr_i);
      power_q   <= PROD_W'(volt) * PROD_W'(curr_i);
      cond_q    <= cond_d;
    end
  end

  assign valid_o   = valid_q;
  assign volt_sq_o = volt_sq_q;
  assign curr_sq_o = curr_sq_q;
  assign power_o   = power_q;
  assign cond_o    = cond_q;

endmodule

// ===== hdl/acpm_accum.sv =====
module acpm_accum #(
  parameter int SAMPLE_BITS = acpm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  acpm_pkg::cfg_t                cfg_i,
  input  logic                          valid_i,
  output logic                          take_o,
  input  logic [2*SAMPLE_BITS-1:0]      volt_sq_i,
  input  logic [2*SAMPLE_BITS-1:0]      curr_sq_i,
  input  logic [2*SAMPLE_BITS-1:0]      power_i,
  input  acpm_pkg::pol_cond_t           cond_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acpm_pkg::ACC_W-1:0]    volt_sq_sum_o,
  output logic [acpm_pkg::ACC_W-1:0]    curr_sq_sum_o,
  output logic [acpm_pkg::PWR_W-1:0]    power_sum_o,
  output logic [acpm_pkg::CNT_W-1:0]    window_samples_o
);
  import acpm_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(1 << (CNT_W - 1));

  logic             pol_q, pol_d;
  logic [ACC_W-1:0] vs_q, cs_q, pw_q;
  logic [ACC_W-1:0] vs_sum, cs_sum, pw_sum;
  logic [CNT_W-1:0] cnt_q, cnt_inc;
  logic             enough, flipped, close;
  logic             out_valid_q;
  logic [ACC_W-1:0] vs_out_q, cs_out_q;
  logic [PWR_W-1:0] pw_out_q;
  logic [CNT_W-1:0] cnt_out_q;
  logic             res_load;

  assign take_o   = valid_i && (!close || !out_valid_q || out_ready_i);
  assign res_load = take_o && close;

  always_comb begin
    enough = cnt_q > CNT_W'(cfg_i.pol_min);
    pol_d  = pol_q;
    if (!pol_q) begin
      if (cond_i.rise && enough) pol_d = 1'b1;
    end else begin
      if (cond_i.fall && enough) pol_d = 1'b0;
    end
    flipped = pol_d != pol_q;
    cnt_inc = cnt_q + 1'b1;
    vs_sum  = vs_q + ACC_W'(volt_sq_i);
    cs_sum  = cs_q + ACC_W'(curr_sq_i);
    pw_sum  = pw_q + ACC_W'(power_i);
    close   = (flipped && (cnt_inc > CNT_W'(cfg_i.win_min)))
              || (cnt_inc > CNT_W'(cfg_i.win_max));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= 1'b0;
      vs_q  <= '0;
      cs_q  <= '0;
      pw_q  <= '0;
      cnt_q <= '0;
    end else if (take_o) begin
      pol_q <= pol_d;
      if (close) begin
        vs_q  <= '0;
        cs_q  <= '0;
        pw_q  <= '0;
        cnt_q <= '0;
      end else begin
        vs_q  <= vs_sum;
        cs_q  <= cs_sum;
        pw_q  <= pw_sum;
        cnt_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      vs_out_q  <= vs_sum;
      cs_out_q  <= cs_sum;
      pw_out_q  <= pw_sum[ACC_W-1:POWER_SHIFT];
      cnt_out_q <= cnt_inc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign volt_sq_sum_o    = vs_out_q;
  assign curr_sq_sum_o    = cs_out_q;
  assign power_sum_o      = pw_out_q;
  assign window_samples_o = cnt_out_q;

`ifndef ASSERT_OFF
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_LIMIT)
    else $error("window count out of range");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (cnt_q == '0) && (vs_q == '0) && (pw_q == '0))
    else $error("accumulators not cleared after window close");

  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_q && (cnt_out_q != '0))
    else $error("empty window emitted");

  a_pol_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> $stable(pol_q) && $stable(cnt_q))
    else $error("state moved without a beat");
`endif

endmodule

// ===== hdl/ac_power_meter_accumulator_core.sv =====
// rms and active power accumulator for one mains phase. each input beat carries line,
// neutral and current adc codes; one beat is taken every clock cycle while the
// accumulator stage takes beats. a beat passes a product register (|line-neutral|
// squared, current squared, their product, polarity compare against the hysteresis)
// and then the accumulator stage, which updates polarity, the three 36-bit sums and
// the count and, when the window closes, loads the result register that drives the
// output. the result register decouples the output: input beats keep flowing while a
// result waits, until a second closing beat reaches the accumulator stage. write the
// configuration registers only while no beat is in flight.
module ac_power_meter_accumulator_core #(
  parameter int SAMPLE_BITS = acpm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // line_sample, neutral_sample, current_sample
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // volt_sq_sum, curr_sq_sum, power_sum, window_samples
  output logic [2*acpm_pkg::ACC_W+acpm_pkg::PWR_W+acpm_pkg::CNT_W-1:0] m_axis_tdata,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [acpm_pkg::CFG_ADDR_W-1:0]            paddr,
  input  logic [acpm_pkg::CFG_DATA_W-1:0]            pwdata,
  output logic [acpm_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                       pready
);
  import acpm_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;

  cfg_t              cfg;
  pol_cond_t         cond;
  logic              p_valid, take;
  logic [PROD_W-1:0] volt_sq, curr_sq, power;
  logic [ACC_W-1:0]  volt_sq_sum, curr_sq_sum;
  logic [PWR_W-1:0]  power_sum;
  logic [CNT_W-1:0]  window_samples;

  acpm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  acpm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .line_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .neut_i     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .curr_i     (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .cfg_i      (cfg),
    .take_i     (take),
    .valid_o    (p_valid),
    .volt_sq_o  (volt_sq),
    .curr_sq_o  (curr_sq),
    .power_o    (power),
    .cond_o     (cond)
  );

  acpm_accum #(.SAMPLE_BITS(SAMPLE_BITS)) u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (p_valid),
    .take_o           (take),
    .volt_sq_i        (volt_sq),
    .curr_sq_i        (curr_sq),
    .power_i          (power),
    .cond_i           (cond),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .volt_sq_sum_o    (volt_sq_sum),
    .curr_sq_sum_o    (curr_sq_sum),
    .power_sum_o      (power_sum),
    .window_samples_o (window_samples)
  );

  assign m_axis_tdata = {window_samples, power_sum, curr_sq_sum, volt_sq_sum};

endmodule

// ===== bench/tb_ac_power_meter_accumulator_core.sv =====
module tb_ac_power_meter_accumulator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import acpm_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int SETTLE_CYC  = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [3:0]  pad;
    logic [11:0] cur;
    logic [11:0] neut;
    logic [11:0] line;
  } sample_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [PWR_W-1:0] pwr;
    logic [ACC_W-1:0] isq;
    logic [ACC_W-1:0] vsq;
  } window_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_BEAT
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [31:0] wdata;
    logic [11:0] line;
    logic [11:0] neut;
    logic [11:0] cur;
    logic        typed;
    window_t     res;
  } row_t;

  localparam row_t DIRECTED [32] = '{
    // every beat closes its own window
    '{ROW_WRITE, REG_WIN_MAX, 32'hFFFF_F800, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd4095, 12'd0, 12'd4095, 1'b1,
      '{12'd1, 28'd65504, 36'd16769025, 36'd16769025}},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd0, 12'd4095, 12'd0, 1'b1,
      '{12'd1, 28'd0, 36'd0, 36'd16769025}},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd0, 12'd0, 12'd0, 1'b1,
      '{12'd1, 28'd0, 36'd0, 36'd0}},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1,
      '{12'd1, 28'd0, 36'd16769025, 36'd0}},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd2048, 12'd2047, 12'd1, 1'b1,
      '{12'd1, 28'd0, 36'd1, 36'd1}},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd2047, 12'd2048, 12'd4095, 1'b1,
      '{12'd1, 28'd15, 36'd16769025, 36'd1}},
    // zero hysteresis, flips close the window
    '{ROW_WRITE, REG_HYST, 32'h1234_5600, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_WRITE, REG_POL_MIN, 32'd2, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_WRITE, REG_WIN_MIN, 32'd3, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_WRITE, REG_WIN_MAX, 32'h0000_07FF, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd3000, 12'd1000, 12'd100, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd3000, 12'd1000, 12'd200, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd3000, 12'd1000, 12'd300, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd3000, 12'd1000, 12'd400, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd1000, 12'd500, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1001, 12'd1000, 12'd600, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd1001, 12'd700, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd1002, 12'd800, 1'b0, '0},
    // full hysteresis, margin exactly at and one above
    '{ROW_WRITE, REG_HYST, 32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd300, 12'd45, 12'd0, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd300, 12'd45, 12'd1, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd300, 12'd45, 12'd2, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd300, 12'd45, 12'd3, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd301, 12'd45, 12'd4095, 1'b0, '0},
    // flip below the window minimum, close on the maximum
    '{ROW_WRITE, REG_WIN_MIN, 32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_WRITE, REG_WIN_MAX, 32'hABCD_E004, 12'd0, 12'd0, 12'd0, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd3000, 12'd4095, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd3000, 12'd2048, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd3000, 12'd1, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd3000, 12'd2730, 1'b0, '0},
    '{ROW_BEAT, REG_HYST, 32'd0, 12'd1000, 12'd3000, 12'd1365, 1'b0, '0}
  };

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  // line_sample, neutral_sample, current_sample, zero pad
  logic [39:0]   s_axis_tdata  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // volt_sq_sum, curr_sq_sum, power_sum, window_samples
  logic [111:0]  m_axis_tdata;
  logic          psel          = 1'b0;
  logic          penable       = 1'b0;
  logic          pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr  = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic          pready;

  // predictor state and configuration
  logic [HYST_W-1:0] hyst_cfg    = HYST_RST;
  logic [LIM_W-1:0]  pol_min_cfg = PMIN_RST;
  logic [LIM_W-1:0]  win_min_cfg = WMIN_RST;
  logic [LIM_W-1:0]  win_max_cfg = WMAX_RST;
  logic              pol_now     = 1'b0;
  logic              pol_prev    = 1'b0;
  logic [ACC_W-1:0]  vsq_acc     = '0;
  logic [ACC_W-1:0]  isq_acc     = '0;
  logic [ACC_W-1:0]  pwr_acc     = '0;
  logic [CNT_W-1:0]  win_count   = '0;

  window_t window_sums_q[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt    = 0;
  int      send_idle    = 0;
  int      recv_idle    = 0;

  ac_power_meter_accumulator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[ac_power_meter_accumulator_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic flag_mismatch(input string what, input logic [35:0] got,
                               input logic [35:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic logic [11:0] clamp_code(input int x);
    if (x < 0) return 12'd0;
    if (x > 4095) return 12'd4095;
    return x[11:0];
  endfunction

  // one sample into the window; returns 1 when the window closes
  function automatic bit mains_window_step(input sample_t s, output window_t res);
    logic [11:0] mag;
    bit          enough;
    bit          closes;
    mag = (s.line > s.neut) ? s.line - s.neut : s.neut - s.line;
    enough = win_count > CNT_W'(pol_min_cfg);
    if (!pol_now) begin
      if (int'(s.line) > int'(s.neut) + int'(hyst_cfg) && enough) pol_now = 1'b1;
    end else begin
      if (int'(s.neut) > int'(s.line) + int'(hyst_cfg) && enough) pol_now = 1'b0;
    end
    vsq_acc = vsq_acc + ACC_W'(mag) * ACC_W'(mag);
    isq_acc = isq_acc + ACC_W'(s.cur) * ACC_W'(s.cur);
    pwr_acc = pwr_acc + ACC_W'(mag) * ACC_W'(s.cur);
    win_count = win_count + 1'b1;
    closes = (pol_now != pol_prev && win_count > CNT_W'(win_min_cfg)) ||
             win_count > CNT_W'(win_max_cfg);
    res.cnt = win_count;
    res.pwr = pwr_acc[ACC_W-1:POWER_SHIFT];
    res.isq = isq_acc;
    res.vsq = vsq_acc;
    if (closes) begin
      vsq_acc = '0;
      isq_acc = '0;
      pwr_acc = '0;
      win_count = '0;
    end
    pol_prev = pol_now;
    return closes;
  endfunction

  task automatic send_beat(input sample_t s, input bit typed, input window_t typed_res);
    window_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mains_window_step(s, res)) window_sums_q.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (window_sums_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e r, input logic [31:0] d);
    logic [31:0] rb;
    case (r)
      REG_HYST: begin
        hyst_cfg = d[HYST_W-1:0];
        rb = 32'(d[HYST_W-1:0]);
      end
      REG_POL_MIN: begin
        pol_min_cfg = d[LIM_W-1:0];
        rb = 32'(d[LIM_W-1:0]);
      end
      REG_WIN_MIN: begin
        win_min_cfg = d[LIM_W-1:0];
        rb = 32'(d[LIM_W-1:0]);
      end
      REG_WIN_MAX: begin
        win_max_cfg = d[LIM_W-1:0];
        rb = 32'(d[LIM_W-1:0]);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== rb) flag_mismatch($sformatf("register %s", r.name()), 36'(prdata), 36'(rb));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    window_t got;
    window_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (window_sums_q.size() == 0) begin
        flag_mismatch("result with no window closed, count", 36'(got.cnt), 36'd0);
      end else begin
        want = window_sums_q.pop_front();
        if (got.vsq !== want.vsq) flag_mismatch("volt_sq_sum", got.vsq, want.vsq);
        if (got.isq !== want.isq) flag_mismatch("curr_sq_sum", got.isq, want.isq);
        if (got.pwr !== want.pwr) flag_mismatch("power_sum", 36'(got.pwr), 36'(want.pwr));
        if (got.cnt !== want.cnt) flag_mismatch("window_samples", 36'(got.cnt), 36'(want.cnt));
      end
    end
  end

  initial begin : stimulus
    sample_t smp;
    int      n_items;
    int      amp_max;
    int      per_lo;
    int      per_hi;
    int      period;
    int      pos;
    int      amp;
    int      half;
    int      level;
    logic [HYST_W-1:0] h;
    logic [LIM_W-1:0]  pm;
    logic [LIM_W-1:0]  wn;
    logic [LIM_W-1:0]  wx;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].kind == ROW_WRITE) begin
        settle();
        cfg_write(DIRECTED[k].idx, DIRECTED[k].wdata);
      end else begin
        smp = '{pad: 4'd0, cur: DIRECTED[k].cur, neut: DIRECTED[k].neut,
                line: DIRECTED[k].line};
        send_beat(smp, DIRECTED[k].typed, DIRECTED[k].res);
      end
    end

    period = 40;
    pos    = 0;
    amp    = 1000;
    for (int ph = 0; ph < 7; ph++) begin
      amp_max = 2000;
      per_lo  = 10;
      per_hi  = 200;
      n_items = 100;
      case (ph)
        0: begin
          h = HYST_W'($urandom_range(0, 60));
          pm = LIM_W'($urandom_range(0, 60));
          wn = LIM_W'($urandom_range(0, 80));
          wx = LIM_W'($urandom_range(30, 300));
          per_lo = 20;
          per_hi = 160;
          n_items = 150;
        end
        1: begin
          h = 8'd255;
          pm = '0;
          wn = '0;
          wx = 11'd2047;
          per_lo = 8;
          per_hi = 40;
          n_items = 120;
        end
        2: begin
          h = '0;
          pm = 11'd2047;
          wn = 11'd2047;
          wx = LIM_W'($urandom_range(0, 40));
          n_items = 100;
        end
        6: begin
          // one long window closed by the maximum, margin kept inside the hysteresis
          h = 8'd255;
          pm = '0;
          wn = '0;
          wx = 11'd649;
          n_items = 650;
        end
        default: begin
          h = HYST_W'($urandom_range(0, 255));
          pm = LIM_W'($urandom_range(0, 100));
          wn = LIM_W'($urandom_range(0, 150));
          wx = LIM_W'($urandom_range(0, 400));
        end
      endcase
      settle();
      send_idle = (ph < 2) ? 33 : (ph < 4) ? 45 : 0;
      recv_idle = (ph < 2) ? 45 : (ph < 4) ? 33 : 0;
      cfg_write(REG_HYST, (32'($urandom) << HYST_W) | 32'(h));
      cfg_write(REG_POL_MIN, (32'($urandom) << LIM_W) | 32'(pm));
      cfg_write(REG_WIN_MIN, (32'($urandom) << LIM_W) | 32'(wn));
      cfg_write(REG_WIN_MAX, (32'($urandom) << LIM_W) | 32'(wx));

      for (int n = 0; n < n_items; n++) begin
        if (ph == 1 && n == 100) settle();
        smp.pad = 4'd0;
        smp.cur = 12'($urandom_range(0, 4095));
        if (ph == 6) begin
          smp.line = 12'($urandom_range(0, 4095));
          smp.neut = clamp_code(int'(smp.line) + int'($urandom_range(0, 400)) - 200);
        end else if ($urandom_range(0, 99) < 15) begin
          smp.line = 12'($urandom_range(0, 4095));
          smp.neut = 12'($urandom_range(0, 4095));
        end else begin
          pos++;
          if (pos >= period) begin
            pos = 0;
            period = $urandom_range(per_lo, per_hi);
            amp = $urandom_range(0, amp_max);
          end
          half = period / 2;
          if (pos < half) level = -amp + (2 * amp * pos) / half;
          else level = amp - (2 * amp * (pos - half)) / (period - half);
          smp.line = clamp_code(2048 + level / 2 + int'($urandom_range(0, 40)) - 20);
          smp.neut = clamp_code(2048 - level / 2 + int'($urandom_range(0, 40)) - 20);
        end
        send_beat(smp, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (window_sums_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ac_power_meter_accumulator_core] OK");
    end else begin
      $display("[ac_power_meter_accumulator_core] ERROR");
    end
    $finish;
  end

endmodule
